/* hdl/sws_pkg.sv */
package sws_pkg;

   // word and position geometry
   localparam int WORD_W     = 64;
   localparam int SHIFT_W    = 6;
   localparam int CNT_W      = 21;
   localparam int MEM_WORDS  = 1048576;
   localparam int TOTAL_W    = CNT_W + SHIFT_W;
   localparam int POS_W      = 28;
   localparam int LANE_POS_W = 32;
   localparam int OUT_POS_W  = 26;
   localparam int STEP_W     = 27;
   localparam int START_W    = 26;
   localparam int END_W      = 27;

   // lane array
   localparam int LANES      = 16;
   localparam int LANE_IDX_W = 4;
   localparam int LANE_SEL_W = 5;
   localparam int MAX_HITS   = 64;
   localparam int HIT_CNT_W  = 7;

   // result status codes
   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] ST_HIT       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MASK_ERR  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_START_ERR = 2'd2;

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_END    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WORDS  = 3'd5;

   // what the merge stage found in one lane batch
   typedef struct packed {
      logic                  any_hit;
      logic [LANE_IDX_W-1:0] hit_idx;
      logic [LANES-1:0]      hit_rest;
      logic                  all_valid;
      logic [LANE_IDX_W-1:0] stop_idx;
   } merge_status_type;

endpackage

/* hdl/sws_lane.sv */
module sws_lane (
   input  logic [sws_pkg::LANE_POS_W-1:0] lane_pos,
   input  logic [sws_pkg::TOTAL_W-1:0]    base,
   input  logic [sws_pkg::TOTAL_W-1:0]    hi,
   input  logic [sws_pkg::WORD_W-1:0]     cur_word,
   input  logic [sws_pkg::WORD_W-1:0]     prev_word,
   input  logic [sws_pkg::WORD_W-1:0]     mask,
   input  logic [sws_pkg::WORD_W-1:0]     expect_value,
   output logic                           lane_ok,
   output logic                           lane_hit
);
   import sws_pkg::*;

   logic [SHIFT_W-1:0]    shift;
   logic [2*WORD_W-1:0]   pair;
   logic [WORD_W-1:0]     window;
   logic [LANE_POS_W-1:0] base_ext;
   logic [LANE_POS_W-1:0] hi_ext;
   logic [LANE_POS_W:0]   win_end;

   assign base_ext = LANE_POS_W'(base);
   assign hi_ext   = LANE_POS_W'(hi);

   // build the window from the upper bits of the previous word and the current word
   assign shift  = lane_pos[SHIFT_W-1:0];
   assign pair   = {cur_word, prev_word} >> shift;
   assign window = (lane_pos == base_ext) ? cur_word : pair[WORD_W-1:0];

   // window must start no later than this word and end below the bound
   assign win_end = {1'b0, lane_pos} + (LANE_POS_W+1)'(WORD_W);
   assign lane_ok = (lane_pos <= base_ext) && (win_end <= {1'b0, hi_ext});

   assign lane_hit = lane_ok && ((window & mask) == expect_value);

endmodule

/* hdl/sws_merge.sv */
module sws_merge (
   input  logic [sws_pkg::LANES-1:0] hit_vec,
   input  logic [sws_pkg::LANES-1:0] ok_vec,
   output sws_pkg::merge_status_type merge_status
);
   import sws_pkg::*;

   // pick the lowest hitting lane and the first lane out of range
   always_comb begin
      merge_status.any_hit   = |hit_vec;
      merge_status.hit_idx   = '0;
      merge_status.hit_rest  = hit_vec & (hit_vec - LANES'(1));
      merge_status.all_valid = &ok_vec;
      merge_status.stop_idx  = '0;
      for (int i = LANES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            merge_status.hit_idx = LANE_IDX_W'(i);
         end
         if (!ok_vec[i]) begin
            merge_status.stop_idx = LANE_IDX_W'(i);
         end
      end
   end

endmodule

/* hdl/sliding_window_bit_pattern_scan_unit.sv */
// Flow: a dropped request (after an error or past the memory end) goes from S_START back to
// S_IDLE; one with a word-mode test or an error result goes through S_START and S_FLUSH and
// waits in S_FLUSH on the result side. Otherwise the word walks batches of 16 lanes through
// S_EVAL and S_MERGE, one hit per S_MERGE pass, bounded by 64 hits; req_stall holds new words until S_IDLE.
// The 16-lane window array and the hold and result registers set this flow.
// Reset: synchronous, active high; loads register defaults and restarts the scan at word 0.
module sliding_window_bit_pattern_scan_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sws_pkg::WORD_W-1:0]      req_word_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sws_pkg::OUT_POS_W-1:0]   rsp_hit_position,
   output logic [sws_pkg::STATUS_W-1:0]    rsp_scan_status,
   output logic                            rsp_run_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sws_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sws_pkg::WORD_W-1:0]      csr_data
);
   import sws_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_MERGE = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [WORD_W-1:0]     mask_ff, expect_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [START_W-1:0]    start_ff;
   logic [END_W-1:0]      end_ff;
   logic [CNT_W-1:0]      words_ff;

   logic [WORD_W-1:0]     cur_ff, cur_in;
   logic [WORD_W-1:0]     prev_ff, prev_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      wcnt_ff, wcnt_in;
   logic                  err_ff, err_in;
   logic [HIT_CNT_W-1:0]  hits_ff, hits_in;
   logic [LANES-1:0]      hit_vec_ff, hit_vec_in;
   logic [LANES-1:0]      ok_vec_ff, ok_vec_in;
   logic                  hold_valid_ff, hold_valid_in;
   logic [OUT_POS_W-1:0]  hold_pos_ff, hold_pos_in;
   logic [STATUS_W-1:0]   hold_status_ff, hold_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]      n_words;
   logic [TOTAL_W-1:0]    mem_bits;
   logic [TOTAL_W-1:0]    hi;
   logic [STEP_W-1:0]     stride;
   logic [TOTAL_W-1:0]    base;
   logic                  first_word;
   logic [STATUS_W-1:0]   chk_status;
   logic                  in_range;
   logic                  word_mode;
   logic [TOTAL_W:0]      hi_round;
   logic [CNT_W:0]        w_hi_raw;
   logic [CNT_W-1:0]      w_hi;
   logic [CNT_W-1:0]      w_lo;
   logic                  word_hit;
   logic [POS_W-1:0]      pos_eff;
   logic                  slot_free;

   logic [LANE_POS_W-1:0] lane_pos [LANES+1];
   logic [LANES-1:0]      lane_ok;
   logic [LANES-1:0]      lane_hit;
   merge_status_type      merge_status;
   logic [LANE_SEL_W-1:0] next_idx;

   // scan bounds from the live registers
   assign n_words    = ({11'b0, words_ff} < 32'(MEM_WORDS)) ? words_ff : CNT_W'(MEM_WORDS);
   assign mem_bits   = {n_words, SHIFT_W'(0)};
   assign hi         = (end_ff < mem_bits) ? end_ff : mem_bits;
   assign stride     = (step_ff == '0) ? STEP_W'(1) : step_ff;
   assign base       = {wcnt_ff, SHIFT_W'(0)};
   assign first_word = (wcnt_ff == '0) && !err_ff;
   assign in_range   = wcnt_ff < n_words;
   assign pos_eff    = first_word ? POS_W'(start_ff) : pos_ff;

   always_comb begin
      if (mask_ff == '0) begin
         chk_status = ST_MASK_ERR;
      end else if (TOTAL_W'(start_ff) >= mem_bits) begin
         chk_status = ST_START_ERR;
      end else begin
         chk_status = ST_HIT;
      end
   end

   // whole-word test range
   assign word_mode = (stride == STEP_W'(WORD_W)) && (start_ff[SHIFT_W-1:0] == '0);
   assign hi_round  = {1'b0, hi} + (TOTAL_W+1)'(WORD_W - 1);
   assign w_hi_raw  = hi_round[TOTAL_W:SHIFT_W];
   assign w_hi      = (w_hi_raw > {1'b0, n_words}) ? n_words : w_hi_raw[CNT_W-1:0];
   assign w_lo      = CNT_W'(start_ff[START_W-1:SHIFT_W]);
   assign word_hit  = (wcnt_ff >= w_lo) && (wcnt_ff < w_hi) &&
                      ((cur_ff & mask_ff) == expect_ff);

   // lane positions, one stride apart
   generate
      for (genvar k = 0; k <= LANES; k++) begin : g_pos
         assign lane_pos[k] = LANE_POS_W'(pos_ff) +
                              LANE_POS_W'(k) * LANE_POS_W'(stride);
      end
      for (genvar k = 0; k < LANES; k++) begin : g_lane
         sws_lane u_lane (
            .lane_pos     (lane_pos[k]),
            .base         (base),
            .hi           (hi),
            .cur_word     (cur_ff),
            .prev_word    (prev_ff),
            .mask         (mask_ff),
            .expect_value (expect_ff),
            .lane_ok      (lane_ok[k]),
            .lane_hit     (lane_hit[k])
         );
      end
   endgenerate

   sws_merge u_merge (
      .hit_vec      (hit_vec_ff),
      .ok_vec       (ok_vec_ff),
      .merge_status (merge_status)
   );

   assign next_idx  = LANE_SEL_W'(merge_status.hit_idx) + LANE_SEL_W'(1);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      pos_in         = pos_ff;
      wcnt_in        = wcnt_ff;
      err_in         = err_ff;
      hits_in        = hits_ff;
      hit_vec_in     = hit_vec_ff;
      ok_vec_in      = ok_vec_ff;
      hold_valid_in  = hold_valid_ff;
      hold_pos_in    = hold_pos_ff;
      hold_status_in = hold_status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_pos_in     = rsp_pos_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cur_in   = req_word_value;
               state_in = S_START;
            end
         end
         S_START: begin
            pos_in = pos_eff;
            if (first_word && (chk_status != ST_HIT)) begin
               // report the error once and mute the rest of the scan
               hold_valid_in  = 1'b1;
               hold_pos_in    = '0;
               hold_status_in = chk_status;
               err_in         = 1'b1;
               wcnt_in        = CNT_W'(1);
               prev_in        = cur_ff;
               state_in       = S_FLUSH;
            end else if (err_ff || !in_range) begin
               // drop the word
               prev_in = cur_ff;
               if (in_range) begin
                  wcnt_in = wcnt_ff + CNT_W'(1);
               end
               state_in = S_IDLE;
            end else if (word_mode) begin
               if (word_hit) begin
                  hold_valid_in  = 1'b1;
                  hold_pos_in    = base[OUT_POS_W-1:0];
                  hold_status_in = ST_HIT;
               end
               prev_in  = cur_ff;
               wcnt_in  = wcnt_ff + CNT_W'(1);
               state_in = S_FLUSH;
            end else begin
               hits_in  = '0;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            hit_vec_in = lane_hit;
            ok_vec_in  = lane_ok;
            state_in   = S_MERGE;
         end
         S_MERGE: begin
            if (merge_status.any_hit) begin
               // hold the newest hit so the last one of the word can be flagged
               if (!hold_valid_ff || slot_free) begin
                  if (hold_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_pos_in    = hold_pos_ff;
                     rsp_status_in = hold_status_ff;
                     rsp_last_in   = 1'b0;
                  end
                  hold_valid_in  = 1'b1;
                  hold_pos_in    =
                     lane_pos[LANE_SEL_W'(merge_status.hit_idx)][OUT_POS_W-1:0];
                  hold_status_in = ST_HIT;
                  hit_vec_in     = merge_status.hit_rest;
                  hits_in        = hits_ff + HIT_CNT_W'(1);
                  if (hits_ff == HIT_CNT_W'(MAX_HITS - 1)) begin
                     pos_in   = lane_pos[next_idx][POS_W-1:0];
                     prev_in  = cur_ff;
                     wcnt_in  = wcnt_ff + CNT_W'(1);
                     state_in = S_FLUSH;
                  end
               end
            end else if (merge_status.all_valid) begin
               // advance to the next batch
               pos_in   = lane_pos[LANES][POS_W-1:0];
               state_in = S_EVAL;
            end else begin
               pos_in   = lane_pos[LANE_SEL_W'(merge_status.stop_idx)][POS_W-1:0];
               prev_in  = cur_ff;
               wcnt_in  = wcnt_ff + CNT_W'(1);
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = S_IDLE;
            end else if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pos_in    = hold_pos_ff;
               rsp_status_in = hold_status_ff;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         prev_ff       <= '0;
         pos_ff        <= '0;
         wcnt_ff       <= '0;
         err_ff        <= 1'b0;
         hits_ff       <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_ff       <= prev_in;
         pos_ff        <= pos_in;
         wcnt_ff       <= wcnt_in;
         err_ff        <= err_in;
         hits_ff       <= hits_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      hit_vec_ff     <= hit_vec_in;
      ok_vec_ff      <= ok_vec_in;
      hold_pos_ff    <= hold_pos_in;
      hold_status_ff <= hold_status_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= '0;
         expect_ff <= '0;
         step_ff   <= STEP_W'(1);
         start_ff  <= '0;
         end_ff    <= END_W'(67108864);
         words_ff  <= CNT_W'(1048576);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MASK:   mask_ff   <= csr_data;
            CSR_EXPECT: expect_ff <= csr_data;
            CSR_STEP:   step_ff   <= csr_data[STEP_W-1:0];
            CSR_START:  start_ff  <= csr_data[START_W-1:0];
            CSR_END:    end_ff    <= csr_data[END_W-1:0];
            CSR_WORDS:  words_ff  <= csr_data[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready        = 1'b1;
   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit_position = rsp_pos_ff;
   assign rsp_scan_status  = rsp_status_ff;
   assign rsp_run_last     = rsp_last_ff;

endmodule

/* hdl/sws_checker.sv */
module sws_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [sws_pkg::OUT_POS_W-1:0]   rsp_hit_position,
   input logic [sws_pkg::STATUS_W-1:0]    rsp_scan_status,
   input logic                            rsp_run_last
);
   import sws_pkg::*;

   logic err_seen_ff;

   // remember that an error request has been delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         err_seen_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall && (rsp_scan_status != ST_HIT)) begin
         err_seen_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit_position) &&
         $stable(rsp_scan_status) && $stable(rsp_run_last))
      else $error("stalled request changed");

   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_scan_status != ST_HIT) |-> (rsp_hit_position == '0) && rsp_run_last)
      else $error("error request not a single zero-position request");

   a_quiet_after_err: assert property (@(posedge clock) disable iff (reset)
      err_seen_ff |-> !rsp_valid)
      else $error("request after error");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("request valid after reset");

endmodule

bind sliding_window_bit_pattern_scan_unit sws_checker u_sws_checker (.*);
